@@ hw/rtl/shpr_pkg.sv @@
// shpr_pkg: types and constants of the sensor-hub packet receiver
// no dependencies; used by the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package shpr_pkg;

  localparam logic [15:0] LEN_ERROR     = 16'hFFFF;
  localparam logic [15:0] CONT_MASK     = 16'h7FFF;
  localparam logic [7:0]  TIMEBASE_MARK = 8'hFB;
  localparam logic [14:0] HDR_BYTES     = 15'd4;
  localparam logic [14:0] MIN_PLAIN     = 15'd15;
  localparam logic [14:0] MIN_BIAS      = 15'd21;
  localparam logic [14:0] MIN_FEATURE   = 15'd17;
  localparam logic [14:0] CAP_FIRST     = 15'd9;
  localparam logic [14:0] CAP_END       = 15'd21;
  localparam int unsigned CAP_COUNT     = 12;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] RESET_REPORT_ID    = 8'd1;
  localparam logic [7:0] RESET_FEATURE_CODE = 8'd252;

  typedef enum logic [2:0] {
    STATUS_MATCH   = 3'd0,
    STATUS_FEATURE = 3'd1,
    STATUS_OTHER   = 3'd2,
    STATUS_LEN_ERR = 3'd3,
    STATUS_NULL    = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REPORT_ID    = 2'd0,
    CFG_BIAS_FORMAT  = 2'd1,
    CFG_FEATURE_CODE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    status_e     packet_status;
    logic [7:0]  channel;
    logic [7:0]  sequence_number;
    logic [14:0] cargo_length;
    logic [15:0] axis_x;
    logic [15:0] axis_y;
    logic [15:0] axis_z;
    logic [15:0] drift_x;
    logic [15:0] drift_y;
    logic [15:0] drift_z;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/shpr_in_if.sv @@
// shpr_in_if: byte channel into the packet receiver
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface shpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       transfer_start;

  modport source (output valid, output rx_byte, output transfer_start, input ready);
  modport sink   (input valid, input rx_byte, input transfer_start, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/shpr_out_if.sv @@
// shpr_out_if: result channel out of the packet receiver
// valid/ready handshake, no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface shpr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  packet_status;
  logic [7:0]  channel;
  logic [7:0]  sequence_number;
  logic [14:0] cargo_length;
  logic [15:0] axis_x;
  logic [15:0] axis_y;
  logic [15:0] axis_z;
  logic [15:0] drift_x;
  logic [15:0] drift_y;
  logic [15:0] drift_z;

  modport source (
    output valid, output packet_status, output channel, output sequence_number,
    output cargo_length, output axis_x, output axis_y, output axis_z,
    output drift_x, output drift_y, output drift_z, input ready
  );
  modport sink (
    input valid, input packet_status, input channel, input sequence_number,
    input cargo_length, input axis_x, input axis_y, input axis_z,
    input drift_x, input drift_y, input drift_z, output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/sensor_hub_packet_receiver_top.sv @@
// sensor_hub_packet_receiver_top: splits a sensor-hub byte stream into packets
// and reports one classified result per packet; uses shpr_pkg, shpr_in_if, shpr_out_if
//
// The receiver takes one byte per clock cycle while input ready is high. Each byte is parsed
// by the header/cargo logic in the cycle it is accepted and a finished packet is
// written to a result register; a second result register acts as a skid stage,
// so bytes keep flowing while one result waits to be taken. Input ready drops
// only when both result registers are full. A result is registered from the byte
// that ends the packet (the fourth header byte on errors or header-only packets,
// otherwise the last cargo byte). Configuration writes
// take effect at the next edge and are to be done while no packet is open.
`timescale 1ns / 1ps
`default_nettype none

module sensor_hub_packet_receiver_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [shpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [shpr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  shpr_in_if.sink                              rx_i,
  shpr_out_if.source                           res_o
);
  import shpr_pkg::*;

  // configuration
  logic [7:0] report_id_q;
  logic       bias_q;
  logic [7:0] feature_code_q;

  // packet state
  logic [14:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  ch_q, ch_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  rid_q, rid_d;
  logic [7:0]  val_q [CAP_COUNT];
  logic [7:0]  val_d [CAP_COUNT];
  logic        inpk_q, inpk_d;

  // values after an optional start-of-transfer clear
  logic [14:0] pos_e;
  logic [15:0] len_e;
  logic [14:0] cargo_idx;
  logic [14:0] cap_off;
  logic [15:0] len_masked;

  logic    accept;
  logic    res_fire;
  status_e res_status;
  logic [14:0] res_cargo;
  result_t res_new;

  // result registers
  result_t head_q, skid_q;
  logic    head_valid_q, skid_valid_q;
  logic    pop;

  function automatic status_e classify(
    input logic [14:0] cargo,
    input logic [7:0]  first,
    input logic [7:0]  rid,
    input logic        bias,
    input logic [7:0]  want,
    input logic [7:0]  feat
  );
    logic [14:0] need;
    need = bias ? MIN_BIAS : MIN_PLAIN;
    if (cargo >= need && first == TIMEBASE_MARK && rid == want) begin
      return STATUS_MATCH;
    end else if (cargo >= MIN_FEATURE && first == feat) begin
      return STATUS_FEATURE;
    end else begin
      return STATUS_OTHER;
    end
  endfunction

  assign accept = rx_i.valid & rx_i.ready;
  assign pop    = head_valid_q & res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_id_q    <= RESET_REPORT_ID;
      bias_q         <= 1'b0;
      feature_code_q <= RESET_FEATURE_CODE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REPORT_ID:    report_id_q    <= cfg_data_i;
        CFG_BIAS_FORMAT:  bias_q         <= cfg_data_i[0];
        CFG_FEATURE_CODE: feature_code_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_e      = rx_i.transfer_start ? '0 : pos_q;
    len_e      = rx_i.transfer_start ? '0 : len_q;
    len_masked = len_e & CONT_MASK;
    cargo_idx  = pos_e - HDR_BYTES;
    cap_off    = cargo_idx - CAP_FIRST;

    pos_d   = pos_q;
    len_d   = len_q;
    ch_d    = ch_q;
    seq_d   = seq_q;
    first_d = first_q;
    rid_d   = rid_q;
    val_d   = val_q;
    inpk_d  = inpk_q;

    res_fire   = 1'b0;
    res_status = STATUS_OTHER;
    res_cargo  = '0;

    if (accept && (rx_i.transfer_start || inpk_q)) begin
      if (rx_i.transfer_start) begin
        ch_d    = '0;
        seq_d   = '0;
        first_d = '0;
        rid_d   = '0;
        for (int i = 0; i < CAP_COUNT; i++) begin
          val_d[i] = '0;
        end
      end
      inpk_d = 1'b1;
      pos_d  = pos_e + 15'd1;
      len_d  = len_e;

      if (pos_e < HDR_BYTES) begin
        case (pos_e[1:0])
          2'd0: len_d = {8'h00, rx_i.rx_byte};
          2'd1: len_d = {rx_i.rx_byte, len_e[7:0]};
          2'd2: ch_d  = rx_i.rx_byte;
          default: begin
            seq_d = rx_i.rx_byte;
            len_d = len_masked;
            if (len_e == LEN_ERROR) begin
              res_fire   = 1'b1;
              res_status = STATUS_LEN_ERR;
            end else if (len_masked < {1'b0, HDR_BYTES}) begin
              res_fire   = 1'b1;
              res_status = STATUS_NULL;
            end else if (len_masked == {1'b0, HDR_BYTES}) begin
              res_fire   = 1'b1;
              res_status = classify('0, first_d, rid_d, bias_q, report_id_q,
                                    feature_code_q);
            end
          end
        endcase
      end else begin
        if (cargo_idx == 15'd0) begin
          first_d = rx_i.rx_byte;
        end else if (cargo_idx == 15'd5) begin
          rid_d = rx_i.rx_byte;
        end else if (cargo_idx >= CAP_FIRST && cargo_idx < CAP_END) begin
          val_d[cap_off[3:0]] = rx_i.rx_byte;
        end
        if ({1'b0, pos_e} + 16'd1 >= len_e) begin
          res_fire   = 1'b1;
          res_cargo  = len_e[14:0] - HDR_BYTES;
          res_status = classify(res_cargo, first_d, rid_d, bias_q, report_id_q,
                                feature_code_q);
        end
      end

      if (res_fire) begin
        inpk_d = 1'b0;
      end
    end

    res_new.packet_status   = res_status;
    res_new.channel         = ch_d;
    res_new.sequence_number = seq_d;
    res_new.cargo_length    = res_cargo;
    res_new.axis_x          = '0;
    res_new.axis_y          = '0;
    res_new.axis_z          = '0;
    res_new.drift_x         = '0;
    res_new.drift_y         = '0;
    res_new.drift_z         = '0;
    if (res_status == STATUS_MATCH) begin
      res_new.axis_x = {val_d[1], val_d[0]};
      res_new.axis_y = {val_d[3], val_d[2]};
      res_new.axis_z = {val_d[5], val_d[4]};
      if (bias_q) begin
        res_new.drift_x = {val_d[7], val_d[6]};
        res_new.drift_y = {val_d[9], val_d[8]};
        res_new.drift_z = {val_d[11], val_d[10]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      ch_q    <= '0;
      seq_q   <= '0;
      first_q <= '0;
      rid_q   <= '0;
      inpk_q  <= 1'b0;
      for (int i = 0; i < CAP_COUNT; i++) begin
        val_q[i] <= '0;
      end
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      ch_q    <= ch_d;
      seq_q   <= seq_d;
      first_q <= first_d;
      rid_q   <= rid_d;
      inpk_q  <= inpk_d;
      val_q   <= val_d;
    end
  end

  // result register plus skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        head_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (res_fire) begin
      if (!head_valid_q || pop) begin
        head_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      head_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        head_q <= skid_q;
      end
    end else if (res_fire) begin
      if (!head_valid_q || pop) begin
        head_q <= res_new;
      end else begin
        skid_q <= res_new;
      end
    end
  end

  assign rx_i.ready = ~skid_valid_q;

  assign res_o.valid           = head_valid_q;
  assign res_o.packet_status   = head_q.packet_status;
  assign res_o.channel         = head_q.channel;
  assign res_o.sequence_number = head_q.sequence_number;
  assign res_o.cargo_length    = head_q.cargo_length;
  assign res_o.axis_x          = head_q.axis_x;
  assign res_o.axis_y          = head_q.axis_y;
  assign res_o.axis_z          = head_q.axis_z;
  assign res_o.drift_x         = head_q.drift_x;
  assign res_o.drift_y         = head_q.drift_y;
  assign res_o.drift_z         = head_q.drift_z;

endmodule

`default_nettype wire

@@ hw/rtl/shpr_checker.sv @@
// shpr_checker: port-level assertions for the packet receiver
// uses shpr_pkg; bound to sensor_hub_packet_receiver_top below
`timescale 1ns / 1ps
`default_nettype none

module shpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [2:0]  status_i,
  input wire logic [14:0] cargo_len_i,
  input wire logic [15:0] axis_x_i,
  input wire logic [15:0] axis_y_i,
  input wire logic [15:0] axis_z_i,
  input wire logic [15:0] drift_x_i,
  input wire logic [15:0] drift_y_i,
  input wire logic [15:0] drift_z_i
);
  import shpr_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(cargo_len_i) && $stable(axis_x_i) && $stable(drift_z_i))
    else $error("stalled result changed");

  // bytes are taken whenever no result is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

  // only a matching report carries sample words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STATUS_MATCH |->
      axis_x_i == '0 && axis_y_i == '0 && axis_z_i == '0
      && drift_x_i == '0 && drift_y_i == '0 && drift_z_i == '0)
    else $error("sample words on a non-matching packet");

  // header errors report no cargo
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STATUS_LEN_ERR || status_i == STATUS_NULL) |->
      cargo_len_i == '0)
    else $error("cargo length on a header error");

endmodule

bind sensor_hub_packet_receiver_top shpr_checker u_shpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (rx_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .status_i    (res_o.packet_status),
  .cargo_len_i (res_o.cargo_length),
  .axis_x_i    (res_o.axis_x),
  .axis_y_i    (res_o.axis_y),
  .axis_z_i    (res_o.axis_z),
  .drift_x_i   (res_o.drift_x),
  .drift_y_i   (res_o.drift_y),
  .drift_z_i   (res_o.drift_z)
);

`default_nettype wire
